/* src/granular_ola_time_stretch_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the time stretcher RTL
// ---------------------------------------------------------------------------
`ifndef GRANULAR_OLA_TIME_STRETCH_DEFINES_SVH
`define GRANULAR_OLA_TIME_STRETCH_DEFINES_SVH

// Concurrent check on clk_i, off while in reset
`define GOLTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold outside reset
`define GOLTS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* src/golts_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_pkg
// Shared constants, types and the window table builder of the time stretcher.
// ---------------------------------------------------------------------------
package golts_pkg;

  localparam int unsigned GrainLength   = 2048;
  localparam int unsigned BufferDepth   = 8192;
  localparam int unsigned JitterSpan    = 64;
  localparam int unsigned GrainCountDef = 4;

  localparam int unsigned HopLength = GrainLength / 2;
  localparam int unsigned PhaseW    = $clog2(GrainLength);
  localparam int unsigned AddrW     = $clog2(BufferDepth);
  localparam int unsigned FillW     = AddrW + 1;
  localparam int unsigned HeadW     = AddrW + 12;
  localparam int unsigned LaunchW   = $clog2(HopLength);
  localparam int unsigned SampleW   = 16;
  localparam int unsigned WinW      = 16;
  localparam int unsigned StretchW  = 15;
  localparam int unsigned ScaleW    = 13;
  localparam int unsigned LcgW      = 32;
  localparam int unsigned DivW      = $clog2(HopLength) + 25;
  localparam int unsigned DvsW      = 15;
  localparam int unsigned JitW      = 9;

  localparam logic [LcgW-1:0] LcgMul = 32'd1664525;
  localparam logic [LcgW-1:0] LcgAdd = 32'd1013904223;
  localparam logic [DvsW-1:0] JitMod = DvsW'(2 * JitterSpan + 1);
  localparam logic [DivW-1:0] AdvNum = DivW'(HopLength) << 24;
  localparam logic [StretchW-1:0] UnityQ12 = 15'd4096;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgStretch = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeed    = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_START,
    ST_ADV_WAIT,
    ST_LCG,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_JIT,
    ST_PLACE,
    ST_HEAD,
    ST_RD,
    ST_MAC,
    ST_OUT
  } golts_state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } golts_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DvsW-1:0] rem;
  } golts_div_rsp_t;

  typedef struct packed {
    logic                      we;
    logic [AddrW-1:0]          waddr;
    logic signed [SampleW-1:0] wl;
    logic signed [SampleW-1:0] wr;
    logic [AddrW-1:0]          raddr;
  } golts_store_req_t;

  typedef struct packed {
    logic signed [SampleW-1:0] rl;
    logic signed [SampleW-1:0] rr;
  } golts_store_rsp_t;

  typedef logic [WinW-1:0] golts_win_tab_t [GrainLength];

  localparam logic [63:0] HannDen = 64'(GrainLength - 1);
  localparam logic [63:0] PiQ30   = 64'd3373259426;
  localparam logic [63:0] TaylorDiv [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // sin^2 window in Q1.15, Taylor series in Q30 on the folded index
  function automatic logic [WinW-1:0] hann_value(logic [63:0] k);
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] w;
    m = (k <= HannDen - k) ? k : HannDen - k;
    t = (m << 30) / HannDen;
    y = (PiQ30 * t) >> 30;
    y2 = (y * y) >> 30;
    term = y;
    sum = y;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * y2) >> 30) / TaylorDiv[n-1];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    w = (((sum * sum) >> 30) + 64'd16384) >> 15;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[WinW-1:0];
  endfunction

  function automatic golts_win_tab_t hann_table();
    golts_win_tab_t tab;
    for (int i = 0; i < GrainLength; i++) begin
      tab[i] = hann_value(64'(i));
    end
    return tab;
  endfunction

endpackage

/* src/golts_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_in_if
// Input sample channel: valid/ready with one stereo sample.
// ---------------------------------------------------------------------------
interface golts_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  in_left;
  logic signed [15:0]  in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

/* src/golts_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_out_if
// Output sample channel: valid/ready with one stereo grain sum.
// ---------------------------------------------------------------------------
interface golts_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_left;
  logic signed [15:0]  out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

/* src/golts_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module golts_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  golts_pkg::golts_div_req_t req_i,
  output golts_pkg::golts_div_rsp_t rsp_o
);
  import golts_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   rsh;
  logic [DvsW:0]   diff;
  logic            ge;

  assign rsh  = {rem_q, quo_q[DivW-1]};
  assign ge   = rsh >= {1'b0, dvs_q};
  assign diff = rsh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], ge};
      rem_d = ge ? diff[DvsW-1:0] : rsh[DvsW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* src/golts_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_store
// Stereo circular sample memory; entries not yet written read as zero.
// ---------------------------------------------------------------------------
module golts_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  golts_pkg::golts_store_req_t req_i,
  output golts_pkg::golts_store_rsp_t rsp_o
);
  import golts_pkg::*;

  logic signed [SampleW-1:0] mem_l [BufferDepth];
  logic signed [SampleW-1:0] mem_r [BufferDepth];
  logic signed [SampleW-1:0] rl_q;
  logic signed [SampleW-1:0] rr_q;
  logic [FillW-1:0]          fill_q, fill_d;
  logic                      hit_q;

  // writes go in address order from zero, so a fill count marks what is live
  assign fill_d = (req_i.we && fill_q != FillW'(BufferDepth)) ? fill_q + 1'b1 : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      hit_q  <= {1'b0, req_i.raddr} < fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_l[req_i.waddr] <= req_i.wl;
      mem_r[req_i.waddr] <= req_i.wr;
    end
    rl_q <= mem_l[req_i.raddr];
    rr_q <= mem_r[req_i.raddr];
  end

  assign rsp_o.rl = hit_q ? rl_q : '0;
  assign rsp_o.rr = hit_q ? rr_q : '0;

endmodule

/* src/golts_win_rom.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// golts_win_rom
// Hann window table, Q1.15, registered read.
// ---------------------------------------------------------------------------
module golts_win_rom (
  input  logic                           clk_i,
  input  logic [golts_pkg::PhaseW-1:0]   addr_i,
  output logic [golts_pkg::WinW-1:0]     data_o
);
  import golts_pkg::*;

  localparam golts_win_tab_t WinTab = hann_table();

  always_ff @(posedge clk_i) begin
    data_o <= WinTab[addr_i];
  end

endmodule

/* src/granular_ola_time_stretch.sv */
`timescale 1ns / 1ps
`include "granular_ola_time_stretch_defines.svh"
// ---------------------------------------------------------------------------
// granular_ola_time_stretch
// Stereo granular overlap-add time stretcher with Hann windowed grains.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one stereo sample per request, out_o one stereo grain sum
//   per request; each input request yields exactly one output request.
//   cfg_we_i/cfg_idx_i/cfg_data_i write stretch_ratio (index 0, Q3.12) and
//   jitter_seed (index 1); write them only while the block is idle.
// Sequence:
//   An ordinary sample visits every grain slot in turn: a free slot takes
//   one pass through the read state, a playing slot a memory read, then a
//   multiply-add. Every HopLength-th sample first launches a grain through
//   the serial divider and the generator, jitter, placement and head states;
//   jitter and placement are skipped when every slot is busy.
// Reset:
//   Stores read as zero until written (fill count, no clearing pass); the
//   first sample launches a grain. in_i.ready is high only in the idle state.
// Stall:
//   The result sits in the output register; the sequencer holds in its
//   output state until that register is free, then accepts the next request.
// ---------------------------------------------------------------------------
module granular_ola_time_stretch #(
  parameter int unsigned GRAIN_COUNT = golts_pkg::GrainCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  golts_in_if.sink                          in_i,
  golts_out_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [golts_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [golts_pkg::CfgDataW-1:0]    cfg_data_i
);
  import golts_pkg::*;

  localparam int unsigned SlotW = (GRAIN_COUNT > 1) ? $clog2(GRAIN_COUNT) : 1;
  localparam int unsigned AccW  = 34 + $clog2(GRAIN_COUNT);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(GRAIN_COUNT - 1);
  localparam logic [9:0] FoldMod  = 10'(JitMod);
  localparam logic [9:0] FoldBias = 10'(2 * JitMod);

  golts_state_e state_q, state_d;

  // configuration and global state
  logic [StretchW-1:0] stretch_q;
  logic [LcgW-1:0]     lcg_q;
  logic [AddrW-1:0]    widx_q;
  logic [HeadW-1:0]    head_q;
  logic [LaunchW-1:0]  launch_q;
  logic [SlotW-1:0]    next_slot_q;

  // grain slots
  logic                grain_busy_q  [GRAIN_COUNT];
  logic [HeadW-1:0]    grain_start_q [GRAIN_COUNT];
  logic [PhaseW-1:0]   grain_phase_q [GRAIN_COUNT];

  // launch datapath
  logic [SlotW-1:0]    slot_q;
  logic [HeadW-1:0]    adv_q;
  logic signed [JitW-1:0] jit_q;
  logic [9:0]          fold_d, fold_q;
  logic [JitW-2:0]     jrem_q;
  logic [SlotW-1:0]    g_q;
  logic signed [AccW-1:0] acc_l_q, acc_r_q;
  logic                out_valid_q;
  logic signed [15:0]  out_l_q, out_r_q;

  // control
  logic in_accept;
  logic launch_now;
  logic out_free;
  logic last_g;
  logic free_found;
  logic [SlotW-1:0] free_slot;

  golts_div_req_t   div_req;
  golts_div_rsp_t   div_rsp;
  golts_store_req_t st_req;
  golts_store_rsp_t st_rsp;
  logic [WinW-1:0]  win;

  logic [StretchW-1:0] s_eff;
  logic [StretchW-1:0] s_diff;
  logic [ScaleW-1:0]   scale;
  logic signed [JitW-1:0] raw;
  logic [JitW-2:0]     raw_mag;
  logic [JitW+ScaleW-2:0] mag_prod;
  logic [JitW-1:0]     mag;
  logic signed [32:0]  prod_l, prod_r;
  logic signed [AccW-1:0] rnd_l, rnd_r;

  assign in_accept  = in_i.valid && in_i.ready;
  assign launch_now = launch_q == LaunchW'(HopLength - 1);
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_g     = g_q == LastSlot;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_accept) state_d = launch_now ? ST_ADV_START : ST_RD;
      ST_ADV_START: state_d = ST_ADV_WAIT;
      ST_ADV_WAIT:  if (div_rsp.done) state_d = ST_LCG;
      ST_LCG:       state_d = free_found ? ST_MOD_START : ST_HEAD;
      ST_MOD_START: state_d = ST_MOD_WAIT;
      ST_MOD_WAIT:  state_d = ST_JIT;
      ST_JIT:       state_d = ST_PLACE;
      ST_PLACE:     state_d = ST_HEAD;
      ST_HEAD:      state_d = ST_RD;
      ST_RD: begin
        if (grain_busy_q[g_q]) state_d = ST_MAC;
        else if (last_g)       state_d = ST_OUT;
      end
      ST_MAC:       state_d = last_g ? ST_OUT : ST_RD;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    in_i.ready       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = AdvNum;
    div_req.divisor  = s_eff;
    unique case (state_q)
      ST_IDLE:      in_i.ready = 1'b1;
      ST_ADV_START: div_req.start = 1'b1;
      default: ;
    endcase
  end

  // zero stretch steps as one; jitter scale is min(|s - 1.0|, 1.0)
  assign s_eff  = (stretch_q == '0) ? StretchW'(1) : stretch_q;
  assign s_diff = (s_eff > UnityQ12) ? s_eff - UnityQ12 : UnityQ12 - s_eff;
  assign scale  = (s_diff > UnityQ12) ? ScaleW'(UnityQ12) : s_diff[ScaleW-1:0];

  // a span of 64 makes the modulus 2^7 + 1: fold 7-bit digits with
  // alternating signs, bias positive, then trim with compare and subtract
  assign fold_d = 10'(lcg_q[6:0]) - 10'(lcg_q[13:7]) + 10'(lcg_q[20:14])
                - 10'(lcg_q[27:21]) + 10'(lcg_q[31:28]) + FoldBias;

  function automatic logic [JitW-2:0] fold_reduce(logic [9:0] v);
    logic [9:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= FoldMod) r = r - FoldMod;
    end
    return r[JitW-2:0];
  endfunction

  assign raw      = $signed({1'b0, jrem_q}) - JitW'(JitterSpan);
  assign raw_mag  = raw[JitW-1] ? (JitW - 1)'(-raw) : raw[JitW-2:0];
  assign mag_prod = raw_mag * scale;
  assign mag      = JitW'(mag_prod[JitW+ScaleW-2:12]);

  // first free slot at or after next_slot; lowest offset wins
  always_comb begin
    logic [SlotW:0] cand;
    free_found = 1'b0;
    free_slot  = '0;
    for (int a = GRAIN_COUNT - 1; a >= 0; a--) begin
      cand = {1'b0, next_slot_q} + (SlotW + 1)'(a);
      if (cand >= (SlotW + 1)'(GRAIN_COUNT)) cand = cand - (SlotW + 1)'(GRAIN_COUNT);
      if (!grain_busy_q[cand[SlotW-1:0]]) begin
        free_found = 1'b1;
        free_slot  = cand[SlotW-1:0];
      end
    end
  end

  // ---- memory side ----
  assign st_req.we    = in_accept;
  assign st_req.waddr = widx_q;
  assign st_req.wl    = in_i.in_left;
  assign st_req.wr    = in_i.in_right;
  assign st_req.raddr = grain_start_q[g_q][HeadW-1:12] + AddrW'(grain_phase_q[g_q]);

  golts_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rsp_o  (st_rsp)
  );

  golts_win_rom u_win (
    .clk_i  (clk_i),
    .addr_i (grain_phase_q[g_q]),
    .data_o (win)
  );

  golts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign prod_l = st_rsp.rl * $signed({1'b0, win});
  assign prod_r = st_rsp.rr * $signed({1'b0, win});

  // round half up: floor((acc + 2^14) / 2^15)
  assign rnd_l = (acc_l_q + AccW'(16384)) >>> 15;
  assign rnd_r = (acc_r_q + AccW'(16384)) >>> 15;

  function automatic logic signed [15:0] sat16(logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(AccW'(32767)))       r = 16'sh7FFF;
    else if (v < -$signed(AccW'(32768))) r = 16'sh8000;
    else                                 r = v[15:0];
    return r;
  endfunction

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stretch_q   <= UnityQ12;
      lcg_q       <= 32'd1;
      widx_q      <= '0;
      head_q      <= '0;
      launch_q    <= LaunchW'(HopLength - 1);
      next_slot_q <= '0;
      g_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < GRAIN_COUNT; i++) begin
        grain_busy_q[i]  <= 1'b0;
        grain_start_q[i] <= '0;
        grain_phase_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStretch) stretch_q <= cfg_data_i[StretchW-1:0];
        if (cfg_idx_i == CfgSeed)    lcg_q     <= cfg_data_i | 32'd1;
      end

      // load a new result when the register frees up, else drop the taken one
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            widx_q   <= widx_q + 1'b1;
            launch_q <= launch_now ? '0 : launch_q + 1'b1;
            g_q      <= '0;
          end
        end
        ST_LCG: begin
          // advance the generator only when a grain really starts
          if (free_found) lcg_q <= lcg_q * LcgMul + LcgAdd;
        end
        ST_PLACE: begin
          grain_busy_q[slot_q]  <= 1'b1;
          grain_phase_q[slot_q] <= '0;
          grain_start_q[slot_q] <= head_q + {{(AddrW - JitW){jit_q[JitW-1]}}, jit_q, 12'b0};
          next_slot_q           <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
        end
        ST_HEAD:  head_q <= head_q + adv_q;
        ST_RD: begin
          if (!grain_busy_q[g_q] && !last_g) g_q <= g_q + 1'b1;
        end
        ST_MAC: begin
          if (grain_phase_q[g_q] == PhaseW'(GrainLength - 1)) begin
            grain_busy_q[g_q]  <= 1'b0;
            grain_phase_q[g_q] <= '0;
          end else begin
            grain_phase_q[g_q] <= grain_phase_q[g_q] + 1'b1;
          end
          if (!last_g) g_q <= g_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end
    if (state_q == ST_ADV_WAIT && div_rsp.done) adv_q <= div_rsp.quot[HeadW-1:0];
    if (state_q == ST_LCG) slot_q <= free_slot;
    if (state_q == ST_MOD_START) fold_q <= fold_d;
    if (state_q == ST_MOD_WAIT) jrem_q <= fold_reduce(fold_q);
    if (state_q == ST_JIT) jit_q <= raw[JitW-1] ? -$signed(mag) : $signed(mag);
    if (state_q == ST_MAC) begin
      acc_l_q <= acc_l_q + AccW'(prod_l);
      acc_r_q <= acc_r_q + AccW'(prod_r);
    end
    if (state_q == ST_OUT && out_free) begin
      out_l_q <= sat16(rnd_l);
      out_r_q <= sat16(rnd_r);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;

  // ---- checks ----
  `GOLTS_ASSERT(a_div_done_waited, div_rsp.done |-> state_q == ST_ADV_WAIT, "divider done early")
  `GOLTS_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q) == ST_OUT, "stray result")
  `GOLTS_ASSERT(a_place_busy, state_q == ST_PLACE |=> grain_busy_q[$past(slot_q)], "grain not busy")

endmodule

/* tb/tb_stream_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stream_if
// Testbench-side note: the channels reuse the block's own interfaces.
// ---------------------------------------------------------------------------
package tb_stream_pkg;
  localparam int unsigned StallPatternW = 16;
endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the granular overlap-add time stretcher.
// A predictor keeps its own copy of the sample stores, grain slots, read
// head and jitter generator; every output sum is compared in order against
// its prediction while the sender bursts and the receiver stalls at random.
// ---------------------------------------------------------------------------
module tb;
  import golts_pkg::*;
  import tb_stream_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  golts_in_if  in_ch();
  golts_out_if out_ch();

  granular_ola_time_stretch u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state, a private mirror of the block
  logic signed [15:0] mdl_left [BufferDepth];
  logic signed [15:0] mdl_right [BufferDepth];
  logic [AddrW-1:0]   mdl_wr_idx;
  logic [HeadW-1:0]   mdl_head;
  int unsigned        mdl_launch_cnt;
  int unsigned        mdl_next_slot;
  logic               mdl_busy [GrainCountDef];
  logic [HeadW-1:0]   mdl_start [GrainCountDef];
  int unsigned        mdl_phase [GrainCountDef];
  logic [31:0]        mdl_lcg;
  logic [14:0]        mdl_stretch;
  logic [15:0]        hann_rom [GrainLength];

  stereo_t expected_sums[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  logic        rx_stall_en;
  logic        burst_mode;
  logic [StallPatternW-1:0] rx_pattern;

  // Own Hann window: sin^2 in Q30 via truncated Taylor series
  function automatic logic [15:0] window_at(int unsigned k);
    logic [63:0] n1, m, t, y, y2, term, acc, w;
    n1 = 64'(GrainLength - 1);
    m = (64'(k) <= n1 - 64'(k)) ? 64'(k) : n1 - 64'(k);
    t = (m << 30) / n1;
    y = (64'd3373259426 * t) >> 30;
    y2 = (y * y) >> 30;
    term = y;
    acc = y;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * y2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    w = (((acc * acc) >> 30) + 64'd16384) >> 15;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[15:0];
  endfunction

  function automatic logic signed [15:0] round_sat(longint acc);
    longint v, q;
    v = acc + 16384;
    q = (v >= 0) ? v / 32768 : -((-v + 32767) / 32768);
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return q[15:0];
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < BufferDepth; i++) begin
      mdl_left[i] = '0;
      mdl_right[i] = '0;
    end
    for (int g = 0; g < GrainCountDef; g++) begin
      mdl_busy[g] = 1'b0;
      mdl_start[g] = '0;
      mdl_phase[g] = 0;
    end
    mdl_wr_idx = '0;
    mdl_head = '0;
    mdl_launch_cnt = GrainLength;
    mdl_next_slot = 0;
    mdl_lcg = 32'd1;
    mdl_stretch = 15'd4096;
    for (int i = 0; i < GrainLength; i++) begin
      hann_rom[i] = window_at(i);
    end
  endtask

  // Start a grain in the first free slot; full slots leave the LCG alone
  function automatic void start_grain(int unsigned s);
    int unsigned slot, scale, mag;
    int raw, jit;
    longint pos;
    for (int a = 0; a < GrainCountDef; a++) begin
      slot = (mdl_next_slot + a) % GrainCountDef;
      if (!mdl_busy[slot]) begin
        scale = (s > 4096) ? s - 4096 : 4096 - s;
        if (scale > 4096) begin
          scale = 4096;
        end
        mdl_lcg = mdl_lcg * LcgMul + LcgAdd;
        raw = int'(mdl_lcg % (2 * JitterSpan + 1)) - int'(JitterSpan);
        mag = ((raw < 0 ? -raw : raw) * scale) >> 12;
        jit = raw < 0 ? -int'(mag) : int'(mag);
        pos = longint'(mdl_head) + longint'(jit) * 4096 + longint'(BufferDepth) * 4096;
        mdl_start[slot] = HeadW'(pos % (longint'(BufferDepth) * 4096));
        mdl_busy[slot] = 1'b1;
        mdl_phase[slot] = 0;
        mdl_next_slot = (slot + 1) % GrainCountDef;
        return;
      end
    end
  endfunction

  // Advance the mirror by one sample and return the stereo grain sum
  function automatic stereo_t predict_grain_sum(stereo_t smp);
    longint acc_l, acc_r, w;
    int unsigned s, idx;
    logic [63:0] adv;
    stereo_t r;
    acc_l = 0;
    acc_r = 0;
    s = (mdl_stretch == 0) ? 1 : mdl_stretch;
    mdl_left[mdl_wr_idx] = smp.left;
    mdl_right[mdl_wr_idx] = smp.right;
    mdl_wr_idx = mdl_wr_idx + 1'b1;
    mdl_launch_cnt++;
    if (mdl_launch_cnt >= HopLength) begin
      adv = (64'(HopLength) << 24) / 64'(s);
      start_grain(s);
      mdl_launch_cnt = 0;
      mdl_head = HeadW'((64'(mdl_head) + adv) % (64'(BufferDepth) * 4096));
    end
    for (int g = 0; g < GrainCountDef; g++) begin
      if (mdl_busy[g]) begin
        idx = ((mdl_start[g] >> 12) + mdl_phase[g]) % BufferDepth;
        w = longint'(hann_rom[mdl_phase[g]]);
        acc_l += longint'(mdl_left[idx]) * w;
        acc_r += longint'(mdl_right[idx]) * w;
        mdl_phase[g]++;
        if (mdl_phase[g] >= GrainLength) begin
          mdl_busy[g] = 1'b0;
          mdl_phase[g] = 0;
        end
      end
    end
    r.left = round_sat(acc_l);
    r.right = round_sat(acc_r);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle budget guard
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver: stall on a rotating pattern of its own when enabled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_pattern <= StallPatternW'(16'hb38d);
    end else begin
      rx_pattern <= {rx_pattern[0], rx_pattern[StallPatternW-1:1]};
      out_ch.ready <= rx_stall_en ? !rx_pattern[0] : 1'b1;
    end
  end

  // Compare each accepted output request against the oldest prediction
  always @(posedge clk_i) begin
    stereo_t exp_sum;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected output %0d %0d", out_ch.out_left, out_ch.out_right);
        end
      end else begin
        exp_sum = expected_sums.pop_front();
        if (out_ch.out_left !== exp_sum.left || out_ch.out_right !== exp_sum.right) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
                     exp_sum.left, exp_sum.right, out_ch.out_left, out_ch.out_right);
          end
        end
      end
    end
  end

  // Send one sample request; hold valid high across a burst
  task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r);
    stereo_t smp;
    smp.left = l;
    smp.right = r;
    in_ch.valid <= 1'b1;
    in_ch.in_left <= l;
    in_ch.in_right <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_sums.push_back(predict_grain_sum(smp));
    // drop valid for a gap unless the burst continues
    if (burst_mode && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end else if (!burst_mode) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    // a launching sample may still be in flight, let the sequencer settle
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgStretch) begin
      mdl_stretch = val[14:0];
    end else if (idx == CfgSeed) begin
      mdl_lcg = val | 32'd1;
    end
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Directed extremes: full-scale, zero and alternating-sign samples
  task automatic test_extremes();
    logic signed [15:0] vals [6] = '{16'sh7fff, 16'sh8000, 16'sh0000,
                                    16'shffff, 16'sh5555, 16'shaaaa};
    burst_mode = 1'b0;
    rx_stall_en = 1'b0;
    for (int i = 0; i < 24; i++) begin
      send_sample(vals[i % 6], vals[(i + 3) % 6]);
    end
    drain();
  endtask

  // Send n samples at one stretch and seed setting
  task automatic test_stretch(logic [14:0] stretch, logic [31:0] seed, int unsigned n);
    write_reg(CfgStretch, {17'd0, stretch});
    write_reg(CfgSeed, seed);
    for (int i = 0; i < n; i++) begin
      if ((i % 200) == 0) begin
        burst_mode = 1'($urandom_range(0, 1));
        rx_stall_en = $urandom_range(0, 2) != 0;
      end
      send_sample(rand_sample(), rand_sample());
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.in_left = '0;
    in_ch.in_right = '0;
    rx_stall_en = 1'b0;
    burst_mode = 1'b0;
    mismatch_cnt = 0;
    reset_predictor();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    // zero stretch acts as the smallest step; max stretch; below and above unity
    test_stretch(15'd0, 32'hffffffff, 60);
    test_stretch(15'h7fff, 32'h00000000, 300);
    test_stretch(15'd1024, $urandom(), 350);
    test_stretch(15'd16384, $urandom(), 350);
    test_stretch(15'd4096, 32'h12345678, 300);
    // a slow stretch below unity with a random seed
    test_stretch(15'd2000, $urandom(), 450);
    for (int k = 0; k < 2; k++) begin
      test_stretch(15'($urandom_range(1024, 16384)), $urandom(), 50);
    end
    // index beyond the register list must be ignored
    write_reg(2'd3, $urandom());
    test_stretch(15'd6000, $urandom(), 20);

    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* granular_ola_time_stretch.f */
+incdir+src
src/golts_pkg.sv
src/golts_in_if.sv
src/golts_out_if.sv
src/golts_div.sv
src/golts_store.sv
src/golts_win_rom.sv
src/granular_ola_time_stretch.sv
tb/tb_stream_if.sv
tb/tb.sv
